// File: rtl/nvis_pkg.sv
// Shared types and codes for the nearest value index search block.
// Depends on nothing; imported by the top level, the checker and the testbench.
package nvis_pkg;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 10;

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_PROBE_RD  = 11'b000_0000_0010,
      S_PROBE_CMP = 11'b000_0000_0100,
      S_BRACKET   = 11'b000_0000_1000,
      S_EQ_CMP    = 11'b000_0001_0000,
      S_BIN_RD    = 11'b000_0010_0000,
      S_BIN_CMP   = 11'b000_0100_0000,
      S_FIN       = 11'b000_1000_0000,
      S_NEAR_A    = 11'b001_0000_0000,
      S_NEAR_B    = 11'b010_0000_0000,
      S_DONE      = 11'b100_0000_0000
   } state_type;

   // Exact distance between two signed values over the full 33-bit difference.
   function automatic logic [VALUE_W:0] abs_diff(input logic signed [VALUE_W-1:0] a,
                                                 input logic signed [VALUE_W-1:0] b);
      logic signed [VALUE_W:0] d;
      d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
      return d[VALUE_W] ? (VALUE_W+1)'(-d) : (VALUE_W+1)'(d);
   endfunction

endpackage

// File: rtl/nvis_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used by the nearest value index search top level.
module nvis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/nearest_value_index_search.sv
// Nearest value index search: a table of signed 32-bit values, which the user is to
// append in ascending order (the block does not enforce it), held in one RAM with a
// registered read. A clear, and an append that fits, finish in the cycle they are
// accepted, the append being written in that cycle; an append to a full table is
// answered with a full status. A query walks a doubling probe and then a binary
// search, with a RAM read state and a compare state for each step; the RAM's single
// read port paces it. One item is worked on at a time; a finished result waits in
// the output register while the next item is taken. Depends on nvis_pkg; uses nvis_ram.
module nearest_value_index_search import nvis_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] found_index, [15:10] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [VALUE_W:0] dist_ff, dist_in;
   logic [CW-1:0] res_ff, res_in;
   logic [1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic req_xfer;
   logic wr_en;
   logic [AW-1:0] rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic signed [VALUE_W-1:0] rd_value;
   logic [CW-1:0] n_m1, lo_m1;
   logic [PW-1:0] pos_dbl, pos_p1, count_ext;
   logic [CW:0] mid_sum;
   logic [CW+INDEX_W-1:0] res_wide;

   nvis_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign wr_en      = req_xfer && (req_tuser == ACT_APPEND) && (count_ff < DEPTH_C);
   assign rd_value   = $signed(rd_data);
   assign n_m1       = count_ff - CW'(1);
   assign lo_m1      = lo_ff - CW'(1);
   assign count_ext  = {1'b0, count_ff};
   assign pos_dbl    = {pos_ff[PW-2:0], 1'b0};
   assign pos_p1     = pos_ff + PW'(1);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in     = mid_sum[CW:1];
   assign res_wide   = {{INDEX_W{1'b0}}, res_ff};

   always_comb begin
      unique case (state_ff)
         S_PROBE_RD: rd_addr = pos_ff[AW-1:0];
         S_BRACKET:  rd_addr = pos_ff[AW:1];
         S_BIN_RD:   rd_addr = mid_in[AW-1:0];
         S_FIN:      rd_addr = lo_ff[AW-1:0];
         S_NEAR_A:   rd_addr = lo_m1[AW-1:0];
         default:    rd_addr = pos_ff[AW-1:0];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      dist_in       = dist_ff;
      res_in        = res_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_tuser)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if (count_ff < DEPTH_C) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_in        = '0;
                        res_status_in = STATUS_FULL;
                        state_in      = S_DONE;
                     end
                  end
                  ACT_QUERY: begin
                     key_in = $signed(req_tdata);
                     if (count_ff == '0) begin
                        res_in        = '0;
                        res_status_in = STATUS_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        pos_in   = PW'(1);
                        state_in = (count_ff > CW'(1)) ? S_PROBE_RD : S_BRACKET;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROBE_RD: begin
            state_in = S_PROBE_CMP;
         end
         S_PROBE_CMP: begin
            if (rd_value < key_ff) begin
               pos_in   = pos_dbl;
               state_in = (pos_dbl < count_ext) ? S_PROBE_RD : S_BRACKET;
            end else begin
               state_in = S_BRACKET;
            end
         end
         S_BRACKET: begin
            lo_in    = pos_ff[PW-1:1];
            hi_in    = (pos_p1 < count_ext) ? pos_p1[CW-1:0] : n_m1;
            state_in = S_EQ_CMP;
         end
         S_EQ_CMP: begin
            if (rd_value == key_ff) begin
               res_in        = lo_ff;
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
            end else begin
               state_in = S_BIN_RD;
            end
         end
         S_BIN_RD: begin
            state_in = S_BIN_CMP;
         end
         S_BIN_CMP: begin
            if (rd_value < key_ff) begin
               lo_in    = mid_ff + CW'(1);
               state_in = (mid_ff == hi_ff) ? S_FIN : S_BIN_RD;
            end else if (rd_value > key_ff) begin
               hi_in    = mid_ff - CW'(1);
               state_in = (mid_ff == lo_ff) ? S_FIN : S_BIN_RD;
            end else begin
               lo_in    = mid_ff;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_status_in = STATUS_OK;
            if (lo_ff >= count_ff) begin
               res_in   = n_m1;
               state_in = S_DONE;
            end else if (lo_ff == '0) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_NEAR_A;
            end
         end
         S_NEAR_A: begin
            dist_in  = abs_diff(rd_value, key_ff);
            state_in = S_NEAR_B;
         end
         S_NEAR_B: begin
            res_in   = (dist_ff < abs_diff(rd_value, key_ff)) ? lo_ff : lo_m1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_wide[INDEX_W-1:0];
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      dist_ff       <= dist_in;
      res_ff        <= res_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - INDEX_W){1'b0}}, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/nvis_chk.sv
// Port-level checker for the nearest value index search block, with its bind.
// Depends on nvis_pkg; attaches to nearest_value_index_search.
module nvis_chk import nvis_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result transfer changed.");

   a_fail_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == 16'd0))
      else $error("Failed request carries a nonzero index.");

   a_clear_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_CLEAR) |=> req_tready)
      else $error("Block busy after a clear transfer.");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ACT_QUERY) |=> !req_tready)
      else $error("Block took a new transfer while a query was in progress.");

endmodule

bind nearest_value_index_search nvis_chk u_nvis_chk (.*);

// File: test/tb_top.sv
// Self-checking testbench for nearest_value_index_search: directed table rows, then random
// table builds and key queries, checked against an in-bench predictor of the search.
// Depends on nvis_pkg and the nearest_value_index_search RTL.
`timescale 1ns / 100ps

module tb_top import nvis_pkg::*; ();

   localparam int TABLE_DEPTH = 1024;
   localparam int ITEM_BUDGET = 1500;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int VALUE_MAX = 32'sh7FFF_FFFF;
   localparam int VALUE_MIN = 32'sh8000_0000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [INDEX_W-1:0] found_index;
      logic [1:0]         status;
   } answer_type;

   typedef struct packed {
      logic [1:0]         act;
      logic [31:0]        value;
      logic               fixed;
      logic [INDEX_W-1:0] exp_index;
      logic [1:0]         exp_status;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 24;

   // Rows with the fixed flag set carry their answer; the rest go to the predictor.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_QUERY,  32'd0,         1'b1, 10'd0, STATUS_EMPTY},
      '{ACT_UNUSED, 32'hFFFF_FFFF, 1'b0, 10'd0, STATUS_OK},
      '{ACT_APPEND, VALUE_MIN,     1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  VALUE_MAX,     1'b1, 10'd0, STATUS_OK},
      '{ACT_QUERY,  VALUE_MIN,     1'b1, 10'd0, STATUS_OK},
      '{ACT_APPEND, -32'sd6,       1'b0, 10'd0, STATUS_OK},
      '{ACT_APPEND, 32'd0,         1'b0, 10'd0, STATUS_OK},
      '{ACT_APPEND, 32'd7,         1'b0, 10'd0, STATUS_OK},
      '{ACT_APPEND, VALUE_MAX,     1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  VALUE_MAX,     1'b1, 10'd4, STATUS_OK},
      '{ACT_QUERY,  VALUE_MIN,     1'b1, 10'd0, STATUS_OK},
      '{ACT_QUERY,  -32'sd3,       1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  32'd3,         1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  32'd7,         1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  32'd100,       1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  32'h8000_0001, 1'b0, 10'd0, STATUS_OK},
      '{ACT_CLEAR,  32'h5555_AAAA, 1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  32'd5,         1'b1, 10'd0, STATUS_EMPTY},
      '{ACT_APPEND, 32'd100,       1'b0, 10'd0, STATUS_OK},
      '{ACT_APPEND, 32'd50,        1'b0, 10'd0, STATUS_OK},
      '{ACT_APPEND, 32'd50,        1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  32'd60,        1'b0, 10'd0, STATUS_OK},
      '{ACT_QUERY,  -32'sd1,       1'b0, 10'd0, STATUS_OK},
      '{ACT_CLEAR,  32'd0,         1'b0, 10'd0, STATUS_OK}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] item_value
   logic [1:0]  req_tuser;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [9:0] found_index, [15:10] zero
   logic [1:0]  rsp_tuser;   // [1:0] status

   int          model_table [TABLE_DEPTH];
   int unsigned model_count;
   answer_type  expected_answers [$];

   int  error_count;
   int  items_offered;
   int  cycle_count;
   int  n_clears;
   int  n_appends;
   int  n_dropped;
   int  n_queries;
   int  n_empty;
   int  n_checked;
   bit  calm;
   bit  hold_pending;

   nearest_value_index_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic int entry_at(input longint i);
      if (i < 0 || i >= TABLE_DEPTH) return 0;
      return model_table[int'(i)];
   endfunction

   function automatic longint distance(input int a, input int b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
   endfunction

   // Doubling probe to bracket the key, binary search inside, then the nearer neighbour.
   function automatic logic [INDEX_W-1:0] closest_index(input int key);
      longint n, pos, lo, hi, mid, pick;
      int     v;
      n = model_count;
      pos = 1;
      while (pos < n && entry_at(pos) < key) pos = pos * 2;
      lo = pos / 2;
      hi = (pos + 1 < n) ? pos + 1 : n - 1;
      if (lo < n && entry_at(lo) == key) begin
         pick = lo;
      end else begin
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            v = entry_at(mid);
            if (v < key) begin
               lo = mid + 1;
            end else if (v > key) begin
               hi = mid - 1;
            end else begin
               lo = mid;
               break;
            end
         end
         if (lo >= n) pick = n - 1;
         else if (lo <= 0) pick = 0;
         else if (distance(entry_at(lo), key) < distance(entry_at(lo - 1), key)) pick = lo;
         else pick = lo - 1;
      end
      return pick[INDEX_W-1:0];
   endfunction

   function automatic void predict_search(input logic [1:0] act, input int val,
                                          output bit has_answer, output answer_type ans);
      has_answer = 1'b0;
      ans = '0;
      case (act)
         ACT_CLEAR: begin
            model_count = 0;
            n_clears++;
         end
         ACT_APPEND: begin
            n_appends++;
            if (model_count >= TABLE_DEPTH) begin
               has_answer = 1'b1;
               ans.status = STATUS_FULL;
               n_dropped++;
            end else begin
               model_table[model_count] = val;
               model_count++;
            end
         end
         ACT_QUERY: begin
            n_queries++;
            has_answer = 1'b1;
            if (model_count == 0) begin
               ans.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               ans.found_index = closest_index(val);
               ans.status = STATUS_OK;
            end
         end
         default: ;
      endcase
   endfunction

   // Offers one item from a falling edge and returns at the rising edge that takes it.
   task automatic send_item(input logic [1:0] act, input int val,
                            input bit use_fixed = 1'b0, input answer_type fixed_ans = '0);
      bit         has_answer;
      answer_type ans;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      if (act != ACT_UNUSED) items_offered++;
      predict_search(act, val, has_answer, ans);
      if (has_answer) expected_answers.push_back(use_fixed ? fixed_ans : ans);
   endtask

   function automatic int pick_key(input int vals[$], input int spread);
      int     r, j;
      longint a, b;
      r = $urandom_range(0, 99);
      if (vals.size() == 0 || r < 15) return $urandom;
      j = $urandom_range(0, vals.size() - 1);
      if (r < 50) return vals[j];
      if (r < 75) return vals[j] + (int'($urandom_range(0, 2 * spread)) - spread);
      if (r < 90 && j > 0) begin
         a = vals[j - 1];
         b = vals[j];
         return int'((a + b + longint'($urandom_range(0, 1))) >>> 1);
      end
      return ($urandom_range(0, 1) == 1) ? VALUE_MAX : VALUE_MIN;
   endfunction

   task automatic run_table_sequence(input bit sorted_values);
      int     vals[$];
      int     k, spread;
      longint base, step;
      if ($urandom_range(0, 9) != 0) send_item(ACT_CLEAR, $urandom);
      k = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
      spread = 1000;
      if (!sorted_values) begin
         for (int i = 0; i < k; i++) begin
            if (vals.size() > 0 && $urandom_range(0, 3) == 0)
               vals.push_back(vals[$urandom_range(0, vals.size() - 1)]);
            else
               vals.push_back($urandom);
         end
      end else if ($urandom_range(0, 1) == 1) begin
         step = $urandom_range(1, 9);
         spread = int'(step) + 1;
         case ($urandom_range(0, 3))
            0:       base = VALUE_MIN;
            1:       base = VALUE_MAX - step * (k - 1);
            default: base = longint'(int'($urandom));
         endcase
         if (base + step * (k - 1) > VALUE_MAX) base = VALUE_MAX - step * (k - 1);
         for (int i = 0; i < k; i++) vals.push_back(int'(base + step * i));
      end else begin
         for (int i = 0; i < k; i++) vals.push_back($urandom);
         if ($urandom_range(0, 3) == 0) vals.push_back(VALUE_MIN);
         if ($urandom_range(0, 3) == 0) vals.push_back(VALUE_MAX);
         vals.sort();
         for (int i = vals.size() - 1; i > 0; i--)
            if (vals[i] == vals[i - 1]) vals.delete(i);
      end
      foreach (vals[i]) send_item(ACT_APPEND, vals[i]);
      repeat ($urandom_range(3, 20)) send_item(ACT_QUERY, pick_key(vals, spread));
   endtask

   // Fills the table to capacity, queries it under a long receiver hold, then overflows it.
   task automatic run_full_table();
      int     vals[$];
      longint acc;
      send_item(ACT_CLEAR, $urandom);
      acc = longint'(VALUE_MIN) + $urandom_range(0, 1000);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         vals.push_back(int'(acc));
         acc += $urandom_range(1, 4_000_000);
      end
      vals[TABLE_DEPTH - 1] = VALUE_MAX;
      foreach (vals[i]) send_item(ACT_APPEND, vals[i]);
      hold_pending = 1'b1;
      repeat (40) send_item(ACT_QUERY, pick_key(vals, 2_000_000));
      repeat (3) send_item(ACT_APPEND, $urandom);
      send_item(ACT_QUERY, VALUE_MAX);
      send_item(ACT_QUERY, VALUE_MIN);
      send_item(ACT_CLEAR, $urandom);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 11);
      end
   end

   always @(posedge clock) begin
      answer_type exp_ans;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("response index %0d status %0d with nothing expected",
                                      rsp_tdata[INDEX_W-1:0], rsp_tuser));
         end else begin
            exp_ans = expected_answers.pop_front();
            n_checked++;
            if (rsp_tdata[INDEX_W-1:0] !== exp_ans.found_index)
               report_mismatch($sformatf("found_index %0d, expected %0d",
                                         rsp_tdata[INDEX_W-1:0], exp_ans.found_index));
            if (rsp_tuser !== exp_ans.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tuser, exp_ans.status));
         end
      end
   end

   initial begin
      int seq, kind, saved_items;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_CLEAR;
      model_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].act, directed_rows[r].value, directed_rows[r].fixed,
                   '{directed_rows[r].exp_index, directed_rows[r].exp_status});

      items_offered = 0;
      seq = 0;
      while (items_offered < ITEM_BUDGET) begin
         if (seq == 30) calm = 1'b1;
         if (seq == 45) calm = 1'b0;
         if (seq == 20) begin
            saved_items = items_offered;
            run_full_table();
            items_offered = saved_items;
         end
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            run_table_sequence(1'b1);
         end else if (kind < 85) begin
            repeat ($urandom_range(4, 12))
               send_item(2'($urandom_range(0, 3)), $urandom);
         end else if (kind < 92) begin
            send_item(ACT_CLEAR, $urandom);
            repeat ($urandom_range(1, 3)) send_item(ACT_QUERY, $urandom);
         end else begin
            run_table_sequence(1'b0);
         end
         seq++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_answers.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_answers.size()));

      $display("Ran %0d clears, %0d appends (%0d dropped on a full table), %0d queries (%0d empty).",
               n_clears, n_appends, n_dropped, n_queries, n_empty);
      $display("Checked %0d responses in %0d cycles; %0d mismatches.",
               n_checked, cycle_count, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: nearest_value_index_search.f
rtl/nvis_pkg.sv
rtl/nvis_ram.sv
rtl/nearest_value_index_search.sv
rtl/nvis_chk.sv
test/tb_top.sv
